FILE: rtl/prrt_pkg.sv
// Shared types and codes for the private region range table.
// Depends on nothing; imported by every module of the block.
package prrt_pkg;

	localparam int unsigned MAX_RANGES_DEF = 256;
	localparam int unsigned ADDR_W = 64;
	localparam int unsigned PROT_W = 3;
	localparam int unsigned USED_W = 9;

	localparam logic [1:0] CMD_TRACK   = 2'd0;
	localparam logic [1:0] CMD_UNTRACK = 2'd1;
	localparam logic [1:0] CMD_QUERY   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_REJECT   = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] base_addr;
		logic [ADDR_W-1:0] span_len;
		logic [PROT_W-1:0] prot_bits;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PROT_W-1:0] found_prot;
		logic [USED_W-1:0] entries_used;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] length;
		logic [PROT_W-1:0] prot;
	} entry_t;

endpackage

FILE: rtl/prrt_cmp.sv
// Shared range compare unit: overlap test or containment test of one entry.
// Depends on prrt_pkg.
module prrt_cmp (
	input  prrt_pkg::entry_t                  entry,
	input  logic [prrt_pkg::ADDR_W-1:0]       span_base,
	input  logic [prrt_pkg::ADDR_W-1:0]       span_end,
	input  logic                              contain,
	output logic                              hit
);
	import prrt_pkg::*;

	logic [ADDR_W-1:0] entry_end;

	assign entry_end = entry.start + entry.length;

	always_comb begin
		if (contain) begin
			hit = (entry.start <= span_base) && (span_end <= entry_end);
		end else begin
			hit = (entry.start < span_end) && (span_base < entry_end);
		end
	end

endmodule

FILE: rtl/private_region_range_table.sv
// Top level of the private region range table: entry memory and sequencer.
// Depends on prrt_pkg and prrt_cmp.
//
//   channel | dir | handshake        | payload
//   req     | in  | req_valid/stall  | prrt_pkg::req_t
//   rsp     | out | rsp_valid/stall  | prrt_pkg::rsp_t
//
// Track writes the entry in S_TRK and then answers from S_DONE; query and untrack
// read one entry per cycle, and an untrack hit adds a step in S_MOVE for the swap
// with the last entry.
// Reset clears the entry count and the sequencer; the memory needs no clear.
// A new request is taken while a result still waits behind rsp_stall; its own
// result holds in S_DONE until the old one leaves.
module private_region_range_table #(
	parameter int unsigned MAX_RANGES = prrt_pkg::MAX_RANGES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  prrt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output prrt_pkg::rsp_t  rsp
);
	import prrt_pkg::*;

	localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TRK,
		S_CMP,
		S_MOVE,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [1:0]        cmd_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] len_q;
	logic [ADDR_W-1:0] end_q;
	logic [PROT_W-1:0] prot_q;
	logic [1:0]        status_q;
	logic [PROT_W-1:0] fprot_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	entry_t            mem [MAX_RANGES];
	entry_t            rdata_q;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wdata;

	logic              hit;
	logic [CNT_W-1:0]  idx_nx;
	logic [CNT_W-1:0]  last;
	logic              req_fire;
	logic              slot_free;

	prrt_cmp u_cmp (
		.entry     (rdata_q),
		.span_base (base_q),
		.span_end  (end_q),
		.contain   (cmd_q == CMD_QUERY),
		.hit       (hit)
	);

	assign idx_nx    = idx_q + CNT_W'(1);
	assign last      = cnt_q - CNT_W'(1);
	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wdata   = rdata_q;
		case (state_q)
			S_IDLE: begin
				rd_en = 1'b1;
			end
			S_CMP: begin
				rd_en = 1'b1;
				if (hit && cmd_q == CMD_UNTRACK) begin
					rd_addr = last[IDX_W-1:0];
				end else begin
					rd_addr = idx_nx[IDX_W-1:0];
				end
			end
			S_TRK: begin
				wr_en   = (base_q != '0) && (cnt_q < CNT_W'(MAX_RANGES));
				wr_addr = cnt_q[IDX_W-1:0];
				wdata   = '{start: base_q, length: len_q, prot: prot_q};
			end
			S_MOVE: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						cmd_q    <= req.cmd;
						base_q   <= req.base_addr;
						len_q    <= req.span_len;
						end_q    <= req.base_addr + req.span_len;
						prot_q   <= req.prot_bits;
						idx_q    <= '0;
						status_q <= (req.cmd == CMD_QUERY && cnt_q == '0) ?
							ST_NOTFOUND : ST_OK;
						fprot_q  <= '0;
						case (req.cmd)
							CMD_TRACK: begin
								state_q <= S_TRK;
							end
							CMD_UNTRACK: begin
								state_q <= (cnt_q == '0) ? S_DONE : S_CMP;
							end
							CMD_QUERY: begin
								state_q <= (cnt_q == '0) ? S_DONE : S_CMP;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_TRK: begin
					if (wr_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						status_q <= ST_REJECT;
					end
					state_q <= S_DONE;
				end
				S_CMP: begin
					if (hit) begin
						if (cmd_q == CMD_QUERY) begin
							fprot_q <= rdata_q.prot;
							state_q <= S_DONE;
						end else begin
							state_q <= S_MOVE;
						end
					end else if (idx_nx >= cnt_q) begin
						if (cmd_q == CMD_QUERY) begin
							status_q <= ST_NOTFOUND;
						end
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_nx;
					end
				end
				S_MOVE: begin
					cnt_q   <= last;
					state_q <= (idx_q >= last) ? S_DONE : S_CMP;
				end
				S_DONE: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= '{status: status_q, found_prot: fprot_q,
							entries_used: USED_W'(cnt_q)};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
